// ----- hw/rtl/ugni_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ugni_pkg;

    // default sizing, handed to the top level parameters
    localparam int MAX_POINTS_DEF    = 4096;
    localparam int MAX_GRID_BITS_DEF = 4;
    localparam int MAX_RESULTS_DEF   = 64;

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int POS_W      = 16;
    localparam int ID_OUT_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GB_CFG_W   = 3;

    // configuration reset values
    localparam logic [POS_W-1:0]    INV_CELL_RST  = 16'd4096;
    localparam logic [GB_CFG_W-1:0] GRID_BITS_RST = 3'd4;

    // last step of the shared multiplier sequence
    localparam logic [2:0] MUL_LAST = 3'd6;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_FINAL  = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORG_X     = 3'd0,
        CFG_ORG_Y     = 3'd1,
        CFG_ORG_Z     = 3'd2,
        CFG_INV_X     = 3'd3,
        CFG_INV_Y     = 3'd4,
        CFG_INV_Z     = 3'd5,
        CFG_GRID_BITS = 3'd6
    } t_cfg_idx;

    // multiplier operand selection: three cell coordinates, three ranges
    typedef enum logic [2:0] {
        MS_GX = 3'd0,
        MS_GY = 3'd1,
        MS_GZ = 3'd2,
        MS_RX = 3'd3,
        MS_RY = 3'd4,
        MS_RZ = 3'd5
    } t_mul_sel;

    typedef enum logic [1:0] {
        CS_SWEEP,
        CS_COP,
        CS_WALK
    } t_cell_src;

    typedef enum logic [1:0] {
        CW_NONE,
        CW_ZERO,
        CW_INC,
        CW_PREFIX
    } t_cell_wr;

    typedef enum logic [1:0] {
        SO_HOLD,
        SO_PREFIX,
        SO_COUNT
    } t_sum_op;

    typedef enum logic {
        OK_ACK,
        OK_ID
    } t_out_kind;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ACK,
        S_MUL,
        S_INS,
        S_BND,
        S_BCHK,
        S_C_RD,
        S_C_ACC,
        S_TSET,
        S_E_RD,
        S_E_CELL,
        S_I_RD,
        S_I_OUT,
        S_F_ZERO,
        S_F_CRD,
        S_F_CCELL,
        S_F_CWR,
        S_F_PRD,
        S_F_PWR,
        S_F_SRD,
        S_F_SCELL,
        S_F_SWR
    } t_state;

    typedef struct packed {
        logic      in_rdy;
        logic      clr_all;
        logic      drop_set;
        logic      rdy_set;
        logic      rdy_clr;
        logic      mul_en;
        t_mul_sel  mul_sel;
        logic      cap_en;
        t_mul_sel  cap_sel;
        logic      cop_wr;
        logic      pi_clr;
        logic      pi_inc;
        logic      cop_rd;
        t_cell_src cell_src;
        logic      cell_rd;
        t_cell_wr  cell_wr;
        logic      ids_wr;
        logic      sweep_clr;
        logic      sweep_inc;
        logic      sum_clr;
        t_sum_op   sum_op;
        logic      bnd_en;
        logic      walk_rst;
        logic      walk_adv;
        logic      total_ld;
        logic      i_ld;
        logic      id_rd;
        logic      out_ld;
        t_out_kind out_kind;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        t_op  in_op;
        logic full;
        logic idx_ready;
        logic pi_done;
        logic sweep_last;
        logic bnd_empty;
        logic walk_done;
        logic sum_zero;
        logic cell_has;
        logic i_next_has;
        logic k_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ----- hw/rtl/ugni_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// input item channel
interface ugni_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [15:0] radius;

    modport source (output valid, operation, pos_x, pos_y, pos_z, radius, input ready);
    modport sink   (input valid, operation, pos_x, pos_y, pos_z, radius, output ready);
endinterface

// result item channel
interface ugni_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] point_id;
    logic        has_point;
    logic        last;
    logic        truncated;
    logic        capacity_overflow;

    modport source (output valid, point_id, has_point, last, truncated, capacity_overflow,
                    input ready);
    modport sink   (input valid, point_id, has_point, last, truncated, capacity_overflow,
                    output ready);
endinterface

// configuration write channel
interface ugni_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ugni_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ugni_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ugni_pkg::t_status i_status,
    output ugni_pkg::t_cmd    o_cmd
);
    import ugni_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       r_isq, n_isq;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 3'd0;
            r_isq   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_isq   <= n_isq;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_isq   = r_isq;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_rdy = 1'b1;
                if (i_status.in_valid) begin
                    unique case (i_status.in_op)
                        OP_CLEAR: begin
                            o_cmd.clr_all = 1'b1;
                            n_state = S_ACK;
                        end
                        OP_INSERT: begin
                            o_cmd.rdy_clr = 1'b1;
                            if (i_status.full) begin
                                o_cmd.drop_set = 1'b1;
                                n_state = S_ACK;
                            end else begin
                                n_step  = 3'd0;
                                n_isq   = 1'b0;
                                n_state = S_MUL;
                            end
                        end
                        OP_FINAL: begin
                            o_cmd.sweep_clr = 1'b1;
                            n_state = S_F_ZERO;
                        end
                        default: begin
                            if (!i_status.idx_ready) begin
                                n_state = S_ACK;
                            end else begin
                                n_step  = 3'd0;
                                n_isq   = 1'b1;
                                n_state = S_MUL;
                            end
                        end
                    endcase
                end
            end
            S_ACK: begin
                if (i_status.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = OK_ACK;
                    n_state = S_IDLE;
                end
            end
            // shared multiplier: issue one product, capture the previous one
            S_MUL: begin
                if (r_step != MUL_LAST) begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = t_mul_sel'(r_step);
                end
                if (r_step != 3'd0) begin
                    o_cmd.cap_en  = 1'b1;
                    o_cmd.cap_sel = t_mul_sel'(r_step - 3'd1);
                end
                n_step = r_step + 3'd1;
                if (r_step == MUL_LAST) begin
                    n_state = r_isq ? S_BND : S_INS;
                end
            end
            S_INS: begin
                o_cmd.cop_wr = 1'b1;
                n_state = S_ACK;
            end
            S_BND: begin
                o_cmd.bnd_en  = 1'b1;
                o_cmd.sum_clr = 1'b1;
                n_state = S_BCHK;
            end
            S_BCHK: begin
                n_state = i_status.bnd_empty ? S_ACK : S_C_RD;
            end
            // first pass: count ids in the cube
            S_C_RD: begin
                o_cmd.cell_src = CS_WALK;
                o_cmd.cell_rd  = 1'b1;
                n_state = S_C_ACC;
            end
            S_C_ACC: begin
                o_cmd.sum_op = SO_COUNT;
                if (i_status.walk_done) begin
                    n_state = S_TSET;
                end else begin
                    o_cmd.walk_adv = 1'b1;
                    n_state = S_C_RD;
                end
            end
            S_TSET: begin
                o_cmd.total_ld = 1'b1;
                o_cmd.walk_rst = 1'b1;
                n_state = i_status.sum_zero ? S_ACK : S_E_RD;
            end
            // second pass: emit ids
            S_E_RD: begin
                o_cmd.cell_src = CS_WALK;
                o_cmd.cell_rd  = 1'b1;
                n_state = S_E_CELL;
            end
            S_E_CELL: begin
                if (i_status.cell_has) begin
                    o_cmd.i_ld = 1'b1;
                    n_state = S_I_RD;
                end else begin
                    o_cmd.walk_adv = 1'b1;
                    n_state = S_E_RD;
                end
            end
            S_I_RD: begin
                o_cmd.id_rd = 1'b1;
                n_state = S_I_OUT;
            end
            S_I_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = OK_ID;
                    if (i_status.k_last) begin
                        n_state = S_IDLE;
                    end else if (i_status.i_next_has) begin
                        n_state = S_I_RD;
                    end else begin
                        o_cmd.walk_adv = 1'b1;
                        n_state = S_E_RD;
                    end
                end
            end
            // finalize: empty every cell
            S_F_ZERO: begin
                o_cmd.cell_src  = CS_SWEEP;
                o_cmd.cell_wr   = CW_ZERO;
                o_cmd.sweep_inc = 1'b1;
                if (i_status.sweep_last) begin
                    o_cmd.pi_clr = 1'b1;
                    n_state = S_F_CRD;
                end
            end
            // finalize: count points per cell
            S_F_CRD: begin
                if (i_status.pi_done) begin
                    o_cmd.sweep_clr = 1'b1;
                    o_cmd.sum_clr   = 1'b1;
                    n_state = S_F_PRD;
                end else begin
                    o_cmd.cop_rd = 1'b1;
                    n_state = S_F_CCELL;
                end
            end
            S_F_CCELL: begin
                o_cmd.cell_src = CS_COP;
                o_cmd.cell_rd  = 1'b1;
                n_state = S_F_CWR;
            end
            S_F_CWR: begin
                o_cmd.cell_src = CS_COP;
                o_cmd.cell_wr  = CW_INC;
                o_cmd.pi_inc   = 1'b1;
                n_state = S_F_CRD;
            end
            // finalize: running sum into cell ranges
            S_F_PRD: begin
                o_cmd.cell_src = CS_SWEEP;
                o_cmd.cell_rd  = 1'b1;
                n_state = S_F_PWR;
            end
            S_F_PWR: begin
                o_cmd.cell_src  = CS_SWEEP;
                o_cmd.cell_wr   = CW_PREFIX;
                o_cmd.sum_op    = SO_PREFIX;
                o_cmd.sweep_inc = 1'b1;
                if (i_status.sweep_last) begin
                    o_cmd.pi_clr = 1'b1;
                    n_state = S_F_SRD;
                end else begin
                    n_state = S_F_PRD;
                end
            end
            // finalize: scatter ids in insertion order
            S_F_SRD: begin
                if (i_status.pi_done) begin
                    o_cmd.rdy_set = 1'b1;
                    n_state = S_ACK;
                end else begin
                    o_cmd.cop_rd = 1'b1;
                    n_state = S_F_SCELL;
                end
            end
            S_F_SCELL: begin
                o_cmd.cell_src = CS_COP;
                o_cmd.cell_rd  = 1'b1;
                n_state = S_F_SWR;
            end
            S_F_SWR: begin
                o_cmd.cell_src = CS_COP;
                o_cmd.cell_wr  = CW_INC;
                o_cmd.ids_wr   = 1'b1;
                o_cmd.pi_inc   = 1'b1;
                n_state = S_F_SRD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ugni_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ugni_dp #(
    parameter int MAX_POINTS    = ugni_pkg::MAX_POINTS_DEF,
    parameter int MAX_GRID_BITS = ugni_pkg::MAX_GRID_BITS_DEF,
    parameter int MAX_RESULTS   = ugni_pkg::MAX_RESULTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ugni_pkg::t_cmd    i_cmd,
    output ugni_pkg::t_status o_status,
    ugni_in_if.sink           i_in,
    ugni_out_if.source        o_out,
    ugni_cfg_if.sink          i_cfg
);
    import ugni_pkg::*;

    localparam int PTS_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int GB_W   = MAX_GRID_BITS;
    localparam int CELL_W = 3 * MAX_GRID_BITS;
    localparam int NCELLS = 1 << CELL_W;
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [CNT_W-1:0] beg;
        logic [CNT_W-1:0] fin;
    } t_cell_word;

    // configuration
    logic [POS_W-1:0]    r_org_x, r_org_y, r_org_z;
    logic [POS_W-1:0]    r_inv_x, r_inv_y, r_inv_z;
    logic [GB_CFG_W-1:0] r_gb;
    logic [2:0]          eb;
    logic [GB_W-1:0]     gmask;

    // control state
    logic [CNT_W-1:0]  r_count;
    logic              r_dropped;
    logic              r_idx_ready;
    logic [CNT_W-1:0]  r_pi;
    logic [CELL_W-1:0] r_sweep;
    logic              r_ov;

    // payload
    logic [POS_W-1:0]    r_pos_x, r_pos_y, r_pos_z, r_radius;
    logic signed [16:0]  mul_a, mul_b;
    logic signed [33:0]  r_prod;
    logic signed [17:0]  cap_g;
    logic [32:0]         cap_sum;
    logic [16:0]         cap_rng;
    logic signed [17:0]  r_g [3];
    logic [16:0]         r_rng;
    logic signed [18:0]  lo_s [3];
    logic signed [18:0]  hi_s [3];
    logic signed [18:0]  lo_c [3];
    logic signed [18:0]  hi_c [3];
    logic signed [18:0]  nmax;
    logic                bnd_empty_c;
    logic [GB_W-1:0]     r_lo [3];
    logic [GB_W-1:0]     r_hi [3];
    logic [GB_W-1:0]     r_c [3];
    logic                r_empty;
    logic [CELL_W-1:0]   walk_hash;
    logic [CELL_W-1:0]   ins_hash;
    logic [CELL_W-1:0]   cell_addr;
    t_cell_word          cell_wdata;
    t_cell_word          r_cell_q;
    logic [CELL_W-1:0]   r_cop_q;
    logic [PTS_W-1:0]    r_id_q;
    logic [CNT_W-1:0]    r_sum;
    logic [RES_W-1:0]    r_total;
    logic [RES_W-1:0]    r_k;
    logic                r_trunc;
    logic [CNT_W-1:0]    r_i, r_iend;
    logic                walk_done;
    logic                out_free;
    logic [ID_OUT_W-1:0] r_o_pid;
    logic                r_o_has, r_o_last, r_o_trunc, r_o_cap;

    // memories
    logic [CELL_W-1:0] cop_mem [MAX_POINTS];
    logic [PTS_W-1:0]  ids_mem [MAX_POINTS];
    t_cell_word        cell_mem [NCELLS];

    function automatic logic [CELL_W-1:0] hash3(input logic [GB_W-1:0] x,
                                               input logic [GB_W-1:0] y,
                                               input logic [GB_W-1:0] z,
                                               input logic [2:0] b);
        hash3 = (CELL_W'(z) << {b, 1'b0}) | (CELL_W'(y) << b) | CELL_W'(x);
    endfunction

    // effective grid bits and axis mask
    always_comb begin
        if (r_gb < 3'd1) begin
            eb = 3'd1;
        end else if (r_gb > 3'(MAX_GRID_BITS)) begin
            eb = 3'(MAX_GRID_BITS);
        end else begin
            eb = r_gb;
        end
        for (int j = 0; j < GB_W; j++) begin
            gmask[j] = (j < int'(eb));
        end
    end

    // multiplier operands
    always_comb begin
        case (i_cmd.mul_sel)
            MS_GX: begin
                mul_a = $signed({1'b0, r_pos_x}) - $signed({1'b0, r_org_x});
                mul_b = $signed({1'b0, r_inv_x});
            end
            MS_GY: begin
                mul_a = $signed({1'b0, r_pos_y}) - $signed({1'b0, r_org_y});
                mul_b = $signed({1'b0, r_inv_y});
            end
            MS_GZ: begin
                mul_a = $signed({1'b0, r_pos_z}) - $signed({1'b0, r_org_z});
                mul_b = $signed({1'b0, r_inv_z});
            end
            MS_RX: begin
                mul_a = $signed({1'b0, r_radius});
                mul_b = $signed({1'b0, r_inv_x});
            end
            MS_RY: begin
                mul_a = $signed({1'b0, r_radius});
                mul_b = $signed({1'b0, r_inv_y});
            end
            default: begin
                mul_a = $signed({1'b0, r_radius});
                mul_b = $signed({1'b0, r_inv_z});
            end
        endcase
    end

    // floor of the coordinate product, ceiling of the range product
    assign cap_g   = r_prod[33:16];
    assign cap_sum = r_prod[32:0] + 33'd65535;
    assign cap_rng = cap_sum[32:16];

    // clamped walk bounds per axis
    always_comb begin
        nmax = $signed((19'd1 << eb) - 19'd1);
        bnd_empty_c = 1'b0;
        for (int a = 0; a < 3; a++) begin
            lo_s[a] = $signed({r_g[a][17], r_g[a]}) - $signed({2'b00, r_rng});
            hi_s[a] = $signed({r_g[a][17], r_g[a]}) + $signed({2'b00, r_rng});
            lo_c[a] = (lo_s[a] < 0) ? 19'sd0 : lo_s[a];
            hi_c[a] = (hi_s[a] > nmax) ? nmax : hi_s[a];
            if (lo_c[a] > hi_c[a]) begin
                bnd_empty_c = 1'b1;
            end
        end
    end

    assign walk_hash = hash3(r_c[0], r_c[1], r_c[2], eb);
    assign ins_hash  = hash3(r_g[0][GB_W-1:0] & gmask, r_g[1][GB_W-1:0] & gmask,
                             r_g[2][GB_W-1:0] & gmask, eb);
    assign walk_done = (r_c[0] == r_hi[0]) && (r_c[1] == r_hi[1]) && (r_c[2] == r_hi[2]);

    // cell memory address and write data
    always_comb begin
        case (i_cmd.cell_src)
            CS_SWEEP: cell_addr = r_sweep;
            CS_COP:   cell_addr = r_cop_q;
            default:  cell_addr = walk_hash;
        endcase
        case (i_cmd.cell_wr)
            CW_INC:    cell_wdata = '{beg: r_cell_q.beg, fin: r_cell_q.fin + CNT_W'(1)};
            CW_PREFIX: cell_wdata = '{beg: r_sum, fin: r_sum};
            default:   cell_wdata = '0;
        endcase
    end

    assign out_free = !r_ov || o_out.ready;

    // configuration writes and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_org_z     <= '0;
            r_inv_x     <= INV_CELL_RST;
            r_inv_y     <= INV_CELL_RST;
            r_inv_z     <= INV_CELL_RST;
            r_gb        <= GRID_BITS_RST;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_idx_ready <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_ORG_X:     r_org_x <= i_cfg.data;
                    CFG_ORG_Y:     r_org_y <= i_cfg.data;
                    CFG_ORG_Z:     r_org_z <= i_cfg.data;
                    CFG_INV_X:     r_inv_x <= i_cfg.data;
                    CFG_INV_Y:     r_inv_y <= i_cfg.data;
                    CFG_INV_Z:     r_inv_z <= i_cfg.data;
                    CFG_GRID_BITS: r_gb    <= i_cfg.data[GB_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_all) begin
                r_count     <= '0;
                r_dropped   <= 1'b0;
                r_idx_ready <= 1'b0;
            end
            if (i_cmd.drop_set) begin
                r_dropped <= 1'b1;
            end
            if (i_cmd.rdy_clr) begin
                r_idx_ready <= 1'b0;
            end
            if (i_cmd.rdy_set) begin
                r_idx_ready <= 1'b1;
            end
            if (i_cmd.cop_wr) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.out_ld) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_cmd.in_rdy) begin
            r_pos_x  <= i_in.pos_x;
            r_pos_y  <= i_in.pos_y;
            r_pos_z  <= i_in.pos_z;
            r_radius <= i_in.radius;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.cap_en) begin
            case (i_cmd.cap_sel)
                MS_GX: r_g[0] <= cap_g;
                MS_GY: r_g[1] <= cap_g;
                MS_GZ: r_g[2] <= cap_g;
                MS_RX: r_rng  <= cap_rng;
                default: begin
                    if (cap_rng > r_rng) begin
                        r_rng <= cap_rng;
                    end
                end
            endcase
        end
        if (i_cmd.bnd_en) begin
            r_empty <= bnd_empty_c;
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= lo_c[a][GB_W-1:0];
                r_hi[a] <= hi_c[a][GB_W-1:0];
                r_c[a]  <= lo_c[a][GB_W-1:0];
            end
        end else if (i_cmd.walk_rst) begin
            for (int a = 0; a < 3; a++) begin
                r_c[a] <= r_lo[a];
            end
        end else if (i_cmd.walk_adv) begin
            // z inner, x outer
            if (r_c[2] != r_hi[2]) begin
                r_c[2] <= r_c[2] + GB_W'(1);
            end else begin
                r_c[2] <= r_lo[2];
                if (r_c[1] != r_hi[1]) begin
                    r_c[1] <= r_c[1] + GB_W'(1);
                end else begin
                    r_c[1] <= r_lo[1];
                    r_c[0] <= r_c[0] + GB_W'(1);
                end
            end
        end
        if (i_cmd.pi_clr) begin
            r_pi <= '0;
        end else if (i_cmd.pi_inc) begin
            r_pi <= r_pi + CNT_W'(1);
        end
        if (i_cmd.sweep_clr) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_inc) begin
            r_sweep <= r_sweep + CELL_W'(1);
        end
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else begin
            case (i_cmd.sum_op)
                SO_PREFIX: r_sum <= r_sum + r_cell_q.fin;
                SO_COUNT:  r_sum <= r_sum + (r_cell_q.fin - r_cell_q.beg);
                default: ;
            endcase
        end
        if (i_cmd.total_ld) begin
            r_k <= '0;
            if (32'(r_sum) > 32'(MAX_RESULTS)) begin
                r_total <= RES_W'(MAX_RESULTS);
                r_trunc <= 1'b1;
            end else begin
                r_total <= RES_W'(r_sum);
                r_trunc <= 1'b0;
            end
        end
        if (i_cmd.i_ld) begin
            r_i    <= r_cell_q.beg;
            r_iend <= r_cell_q.fin;
        end
        // output register
        if (i_cmd.out_ld) begin
            r_o_cap <= r_dropped;
            if (i_cmd.out_kind == OK_ID) begin
                r_o_pid   <= ID_OUT_W'(r_id_q);
                r_o_has   <= 1'b1;
                r_o_last  <= o_status.k_last;
                r_o_trunc <= r_trunc;
                r_k       <= r_k + RES_W'(1);
                r_i       <= r_i + CNT_W'(1);
            end else begin
                r_o_pid   <= '0;
                r_o_has   <= 1'b0;
                r_o_last  <= 1'b1;
                r_o_trunc <= 1'b0;
            end
        end
    end

    // point cell store
    always_ff @(posedge i_clk) begin
        if (i_cmd.cop_wr) begin
            cop_mem[r_count[PTS_W-1:0]] <= ins_hash;
        end
        if (i_cmd.cop_rd) begin
            r_cop_q <= cop_mem[r_pi[PTS_W-1:0]];
        end
    end

    // sorted id store
    always_ff @(posedge i_clk) begin
        if (i_cmd.ids_wr) begin
            ids_mem[r_cell_q.fin[PTS_W-1:0]] <= r_pi[PTS_W-1:0];
        end
        if (i_cmd.id_rd) begin
            r_id_q <= ids_mem[r_i[PTS_W-1:0]];
        end
    end

    // cell range store
    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_wr != CW_NONE) begin
            cell_mem[cell_addr] <= cell_wdata;
        end
        if (i_cmd.cell_rd) begin
            r_cell_q <= cell_mem[cell_addr];
        end
    end

    // status to the controller
    always_comb begin
        o_status.in_valid   = i_in.valid;
        o_status.in_op      = t_op'(i_in.operation);
        o_status.full       = (r_count == CNT_W'(MAX_POINTS));
        o_status.idx_ready  = r_idx_ready;
        o_status.pi_done    = (r_pi == r_count);
        o_status.sweep_last = (r_sweep == CELL_W'(NCELLS - 1));
        o_status.bnd_empty  = r_empty;
        o_status.walk_done  = walk_done;
        o_status.sum_zero   = (r_sum == '0);
        o_status.cell_has   = (r_cell_q.beg < r_cell_q.fin);
        o_status.i_next_has = ({1'b0, r_i} + (CNT_W + 1)'(1)) < {1'b0, r_iend};
        o_status.k_last     = (r_k == r_total - RES_W'(1));
        o_status.out_free   = out_free;
    end

    // ports
    assign i_in.ready              = i_cmd.in_rdy;
    assign i_cfg.ready             = 1'b1;
    assign o_out.valid             = r_ov;
    assign o_out.point_id          = r_o_pid;
    assign o_out.has_point         = r_o_has;
    assign o_out.last              = r_o_last;
    assign o_out.truncated         = r_o_trunc;
    assign o_out.capacity_overflow = r_o_cap;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count above capacity");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cop_wr |-> (r_count != CNT_W'(MAX_POINTS)))
        else $error("point stored while full");

    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_ld |-> (!r_ov || o_out.ready))
        else $error("result register overwritten");

    a_final_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rdy_set |-> (r_pi == r_count))
        else $error("index marked ready before scatter finished");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/uniform_grid_neighbour_index_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// query: walks the clamped cube cell by cell and emits at most MAX_RESULTS ids
// finalize: sweeps all NCELLS cells, NCELLS = 2^(3*MAX_GRID_BITS), with one
//   single-port cell range memory access per cycle
// one item at a time; the next item is taken while the last result waits in the output
// reset: synchronous active low, clears control state and configuration, no memory sweep

module uniform_grid_neighbour_index_core #(
    parameter int MAX_POINTS    = ugni_pkg::MAX_POINTS_DEF,
    parameter int MAX_GRID_BITS = ugni_pkg::MAX_GRID_BITS_DEF,
    parameter int MAX_RESULTS   = ugni_pkg::MAX_RESULTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ugni_in_if.sink    i_in,
    ugni_out_if.source o_out,
    ugni_cfg_if.sink   i_cfg
);
    import ugni_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer
    ugni_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // registers, memories and arithmetic
    ugni_dp #(
        .MAX_POINTS    (MAX_POINTS),
        .MAX_GRID_BITS (MAX_GRID_BITS),
        .MAX_RESULTS   (MAX_RESULTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (i_cfg)
    );

endmodule

`default_nettype wire
